/* design/tjc_pkg.sv */
package tjc_pkg;

   // Junction kinds carried in the kind field.
   typedef enum logic [1:0] {
      KIND_BOUND = 2'd0,
      KIND_COND  = 2'd1,
      KIND_PAIR  = 2'd2
   } kind_type;

   // Reflection coefficient format, signed Q1.14.
   localparam int COEF_WIDTH = 16;
   localparam int COEF_FRAC  = 14;

   // Control that travels with each beat down the pipeline.
   typedef struct packed {
      logic valid;
      logic divp;
      logic neg;
      logic ovf;
      logic err;
      logic pvalid;
   } ctl_type;

endpackage

/* design/tjc_div_stage.sv */
module tjc_div_stage import tjc_pkg::*; #(
   parameter int TW = 34,
   parameter int QW = 33,
   parameter int V  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  ctl_type             ctl_i,
   input  logic [TW-1:0]       rem_i,
   input  logic [TW-1:0]       du_i,
   input  logic [QW-1:0]       nq_i,
   input  logic signed [V-1:0] x_i [4],
   output ctl_type             ctl_o,
   output logic [TW-1:0]       rem_o,
   output logic [TW-1:0]       du_o,
   output logic [QW-1:0]       nq_o,
   output logic signed [V-1:0] x_o [4]
);

   ctl_type             ctl_ff;
   logic [TW-1:0]       rem_ff, rem_in, du_ff;
   logic [QW-1:0]       nq_ff, nq_in;
   logic signed [V-1:0] x_ff [4];
   logic [TW:0]         trial, diff;
   logic                ge;

   // One restoring step: shift in the next numerator bit and try the divisor.
   always_comb begin
      trial  = {rem_i, nq_i[QW-1]};
      diff   = trial - {1'b0, du_i};
      ge     = trial >= {1'b0, du_i};
      rem_in = ge ? diff[TW-1:0] : trial[TW-1:0];
      nq_in  = {nq_i[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         du_ff  <= du_i;
         nq_ff  <= nq_in;
         x_ff   <= x_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign du_o  = du_ff;
   assign nq_o  = nq_ff;
   assign x_o   = x_ff;

endmodule

/* design/tlm_junction_connect.sv */
// Junction connection for a 2D TLM mesh. One junction beat enters per clock and its
// result passes through stages that form products and sums, check the quotient range,
// run a restoring divider one quotient bit per stage, and form and saturate the
// voltages into the output register. The whole pipeline holds while a result waits.
module tlm_junction_connect import tjc_pkg::*; #(
   parameter int VOLT_WIDTH  = 32,
   parameter int ADMIT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic signed [VOLT_WIDTH-1:0]  req_reflected_link_a,
   input  logic signed [VOLT_WIDTH-1:0]  req_stub_volt_a,
   input  logic signed [ADMIT_WIDTH-1:0] req_link_admit_a,
   input  logic signed [ADMIT_WIDTH-1:0] req_stub_admit_a,
   input  logic signed [ADMIT_WIDTH-1:0] req_bound_admit,
   input  logic signed [COEF_WIDTH-1:0]  req_refl_coef,
   input  logic signed [VOLT_WIDTH-1:0]  req_reflected_link_b,
   input  logic signed [VOLT_WIDTH-1:0]  req_stub_volt_b,
   input  logic signed [ADMIT_WIDTH-1:0] req_link_admit_b,
   input  logic signed [ADMIT_WIDTH-1:0] req_stub_admit_b,
   input  logic                          req_conductor_face,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VOLT_WIDTH-1:0]  rsp_incident_link_a,
   output logic signed [VOLT_WIDTH-1:0]  rsp_new_stub_a,
   output logic signed [VOLT_WIDTH-1:0]  rsp_incident_link_b,
   output logic signed [VOLT_WIDTH-1:0]  rsp_new_stub_b,
   output logic                          rsp_partner_valid,
   output logic                          rsp_divide_error
);

   localparam int V   = VOLT_WIDTH;
   localparam int Y   = ADMIT_WIDTH;
   localparam int P   = V + Y;
   localparam int SW  = P + 2;
   localparam int NW  = P + 3;
   localparam int TW  = Y + 2;
   localparam int QW  = V + 1;
   localparam int SCW = V + COEF_WIDTH;
   localparam int RW  = V + 3;

   localparam logic [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
   localparam logic [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

   // Saturate a wide signed value to the voltage width.
   function automatic logic [V-1:0] sat_v(input logic signed [RW-1:0] x);
      logic [RW-V:0] hi;
      hi = x[RW-1:V-1];
      if ((hi == '0) || (hi == '1)) begin
         return x[V-1:0];
      end
      return x[RW-1] ? VMIN : VMAX;
   endfunction

   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // Stage 1: products, coefficient products and admittance total.
   logic                  s1_valid_ff;
   logic [1:0]            s1_kind_ff;
   logic                  s1_coefnz_ff, s1_cond_ff;
   logic signed [P-1:0]   s1_p_ff [4];
   logic signed [P-1:0]   s1_p_in [4];
   logic signed [SCW-1:0] s1_sc_ff [2];
   logic signed [SCW-1:0] s1_sc_in [2];
   logic signed [TW-1:0]  s1_tot_ff, s1_tot_in;
   logic signed [V-1:0]   s1_v_ff [4];
   logic                  pair_in;

   always_comb begin
      pair_in    = req_kind == KIND_PAIR;
      s1_p_in[0] = P'(req_reflected_link_a) * P'(req_link_admit_a);
      s1_p_in[1] = P'(req_stub_volt_a) * P'(req_stub_admit_a);
      s1_p_in[2] = pair_in ? P'(req_reflected_link_b) * P'(req_link_admit_b) : '0;
      s1_p_in[3] = pair_in ? P'(req_stub_volt_b) * P'(req_stub_admit_b) : '0;
      s1_sc_in[0] = SCW'(req_reflected_link_a) * SCW'(req_refl_coef);
      s1_sc_in[1] = SCW'(req_stub_volt_a) * SCW'(req_refl_coef);
      if (pair_in) begin
         s1_tot_in = TW'(req_link_admit_a) + TW'(req_stub_admit_a)
                   + TW'(req_link_admit_b) + TW'(req_stub_admit_b);
      end else begin
         s1_tot_in = TW'(req_link_admit_a) + TW'(req_stub_admit_a) + TW'(req_bound_admit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_kind_ff   <= req_kind;
         s1_coefnz_ff <= req_refl_coef != '0;
         s1_cond_ff   <= req_conductor_face;
         s1_p_ff      <= s1_p_in;
         s1_sc_ff     <= s1_sc_in;
         s1_tot_ff    <= s1_tot_in;
         s1_v_ff[0]   <= req_reflected_link_a;
         s1_v_ff[1]   <= req_stub_volt_a;
         s1_v_ff[2]   <= req_reflected_link_b;
         s1_v_ff[3]   <= req_stub_volt_b;
      end
   end

   // Stage 2: numerator, magnitudes, path selection and non-dividing results.
   ctl_type               s2_ctl_ff, s2_ctl_in;
   logic [NW-1:0]         s2_un_ff, s2_un_in;
   logic [TW-1:0]         s2_du_ff, s2_du_in;
   logic signed [V-1:0]   s2_x_ff [4];
   logic signed [V-1:0]   s2_x_in [4];
   logic signed [SW-1:0]  sum;
   logic signed [NW-1:0]  num;
   logic signed [SCW-1:0] rnd [2];

   always_comb begin
      sum = SW'(s1_p_ff[0]) + SW'(s1_p_ff[1]) + SW'(s1_p_ff[2]) + SW'(s1_p_ff[3]);
      num = {sum, 1'b0};
      s2_un_in = num[NW-1] ? NW'(-num) : NW'(num);
      s2_du_in = s1_tot_ff[TW-1] ? TW'(-s1_tot_ff) : TW'(s1_tot_ff);
      for (int i = 0; i < 2; i++) begin
         rnd[i] = s1_sc_ff[i] + SCW'(1 << (COEF_FRAC - 1));
      end
      s2_ctl_in.valid  = s1_valid_ff;
      s2_ctl_in.neg    = num[NW-1] ^ s1_tot_ff[TW-1];
      s2_ctl_in.ovf    = 1'b0;
      s2_ctl_in.pvalid = s1_kind_ff == KIND_PAIR;
      s2_ctl_in.divp   = ((s1_kind_ff == KIND_BOUND) && !s1_coefnz_ff)
                      || ((s1_kind_ff == KIND_PAIR) && !s1_cond_ff);
      s2_ctl_in.err    = s2_ctl_in.divp && (s1_tot_ff == '0);
      for (int i = 0; i < 4; i++) begin
         s2_x_in[i] = '0;
      end
      case (s1_kind_ff)
         KIND_BOUND: begin
            if (s1_coefnz_ff) begin
               for (int i = 0; i < 2; i++) begin
                  s2_x_in[i] = sat_v(RW'(rnd[i] >>> COEF_FRAC));
               end
            end else begin
               s2_x_in = s1_v_ff;
            end
         end
         KIND_COND: begin
            for (int i = 0; i < 2; i++) begin
               s2_x_in[i] = sat_v(-RW'(s1_v_ff[i]));
            end
         end
         KIND_PAIR: begin
            // A conductor face leaves all four voltages at zero.
            if (!s1_cond_ff) begin
               s2_x_in = s1_v_ff;
            end
         end
         default: begin
            // An undefined kind leaves every voltage at zero.
            s2_x_in[0] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (enable) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_un_ff <= s2_un_in;
         s2_du_ff <= s2_du_in;
         s2_x_ff  <= s2_x_in;
      end
   end

   // Stage 3: flag quotients too wide for the divider and seed the divider.
   ctl_type             dv_ctl [QW+1];
   logic [TW-1:0]       dv_rem [QW+1];
   logic [TW-1:0]       dv_du  [QW+1];
   logic [QW-1:0]       dv_nq  [QW+1];
   logic signed [V-1:0] dv_x   [QW+1][4];
   ctl_type             s3_ctl_ff, s3_ctl_in;
   logic [TW-1:0]       s3_rem_ff, s3_du_ff;
   logic [QW-1:0]       s3_nq_ff;
   logic signed [V-1:0] s3_x_ff [4];

   always_comb begin
      s3_ctl_in     = s2_ctl_ff;
      s3_ctl_in.ovf = s2_un_ff >= {s2_du_ff, {QW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (enable) begin
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_rem_ff <= s2_un_ff[NW-1:QW];
         s3_nq_ff  <= s2_un_ff[QW-1:0];
         s3_du_ff  <= s2_du_ff;
         s3_x_ff   <= s2_x_ff;
      end
   end

   assign dv_ctl[0] = s3_ctl_ff;
   assign dv_rem[0] = s3_rem_ff;
   assign dv_du[0]  = s3_du_ff;
   assign dv_nq[0]  = s3_nq_ff;
   assign dv_x[0]   = s3_x_ff;

   // Divider chain, one quotient bit per stage.
   for (genvar g = 0; g < QW; g++) begin : g_div
      tjc_div_stage #(.TW(TW), .QW(QW), .V(V)) u_stage (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .ctl_i  (dv_ctl[g]),
         .rem_i  (dv_rem[g]),
         .du_i   (dv_du[g]),
         .nq_i   (dv_nq[g]),
         .x_i    (dv_x[g]),
         .ctl_o  (dv_ctl[g+1]),
         .rem_o  (dv_rem[g+1]),
         .du_o   (dv_du[g+1]),
         .nq_o   (dv_nq[g+1]),
         .x_o    (dv_x[g+1])
      );
   end

   // Output reg: signed quotient minus each voltage, saturated, else stage-2 voltages.
   ctl_type              fin_ctl;
   logic signed [RW-1:0] qs;
   logic signed [V-1:0]  o_in [4];
   logic signed [V-1:0]  o_ff [4];
   logic                 o_valid_ff, o_pv_ff, o_err_ff;

   always_comb begin
      fin_ctl = dv_ctl[QW];
      qs = fin_ctl.neg ? -RW'({2'b00, dv_nq[QW]}) : RW'({2'b00, dv_nq[QW]});
      for (int i = 0; i < 4; i++) begin
         if (!fin_ctl.divp) begin
            o_in[i] = dv_x[QW][i];
         end else if (fin_ctl.err || ((i >= 2) && !fin_ctl.pvalid)) begin
            o_in[i] = '0;
         end else if (fin_ctl.ovf) begin
            o_in[i] = fin_ctl.neg ? VMIN : VMAX;
         end else begin
            o_in[i] = sat_v(qs - RW'(dv_x[QW][i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         o_valid_ff <= fin_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         o_ff     <= o_in;
         o_pv_ff  <= fin_ctl.pvalid;
         o_err_ff <= fin_ctl.err;
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_incident_link_a = o_ff[0];
   assign rsp_new_stub_a      = o_ff[1];
   assign rsp_incident_link_b = o_ff[2];
   assign rsp_new_stub_b      = o_ff[3];
   assign rsp_partner_valid   = o_pv_ff;
   assign rsp_divide_error    = o_err_ff;

endmodule

/* tb/sv/tb_tlm_junction_connect.sv */
`timescale 1ns / 1ps

module tb_tlm_junction_connect;
   import tjc_pkg::*;

   localparam int VW = 32;
   localparam int AW = 32;
   localparam int LATENCY = VW + 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT = 1750;

   // Two's-complement limits and unit values for the voltage and admittance widths.
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] YONE = 1 <<< 24;
   localparam logic signed [VW-1:0] VONE = 1 <<< 16;

   typedef struct {
      logic [1:0]             kind;
      logic signed [VW-1:0]   vra;
      logic signed [VW-1:0]   vsa;
      logic signed [AW-1:0]   yla;
      logic signed [AW-1:0]   ysa;
      logic signed [AW-1:0]   yb;
      logic signed [15:0]     coef;
      logic signed [VW-1:0]   vrb;
      logic signed [VW-1:0]   vsb;
      logic signed [AW-1:0]   ylb;
      logic signed [AW-1:0]   ysb;
      logic                   cond;
   } junction_type;

   typedef struct packed {
      logic signed [VW-1:0] link_a;
      logic signed [VW-1:0] stub_a;
      logic signed [VW-1:0] link_b;
      logic signed [VW-1:0] stub_b;
      logic                 pvalid;
      logic                 derr;
   } voltages_type;

   typedef struct {
      junction_type j;
      logic         typed;
      voltages_type v;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic signed [VW-1:0] req_reflected_link_a = '0;
   logic signed [VW-1:0] req_stub_volt_a = '0;
   logic signed [AW-1:0] req_link_admit_a = '0;
   logic signed [AW-1:0] req_stub_admit_a = '0;
   logic signed [AW-1:0] req_bound_admit = '0;
   logic signed [15:0] req_refl_coef = '0;
   logic signed [VW-1:0] req_reflected_link_b = '0;
   logic signed [VW-1:0] req_stub_volt_b = '0;
   logic signed [AW-1:0] req_link_admit_b = '0;
   logic signed [AW-1:0] req_stub_admit_b = '0;
   logic req_conductor_face = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VW-1:0] rsp_incident_link_a;
   logic signed [VW-1:0] rsp_new_stub_a;
   logic signed [VW-1:0] rsp_incident_link_b;
   logic signed [VW-1:0] rsp_new_stub_b;
   logic rsp_partner_valid;
   logic rsp_divide_error;

   voltages_type expected_q[$];
   int errors = 0;
   int beats_out = 0;
   int pair_count = 0;
   int derr_count = 0;
   int idle_cycles = 0;
   bit quiet_tail = 0;
   bit done_sending = 0;

   always #4 clock = ~clock;

   tlm_junction_connect #(.VOLT_WIDTH(VW), .ADMIT_WIDTH(AW)) u_dut (.*);

   // Saturate a wide signed value to the voltage width.
   function automatic logic signed [VW-1:0] clamp_volt(logic signed [127:0] x);
      if (x > 128'sd0 + VMAX) return VMAX;
      if (x < 128'sd0 + VMIN) return VMIN;
      return x[VW-1:0];
   endfunction

   // Coefficient scaling with rounding to nearest, ties upward.
   function automatic logic signed [VW-1:0] scale_by_coef(logic signed [VW-1:0] v,
                                                         logic signed [15:0] c);
      logic signed [127:0] p;
      p = 128'(v) * 128'(c) + (128'sd1 <<< (COEF_FRAC - 1));
      return clamp_volt(p >>> COEF_FRAC);
   endfunction

   // New link and stub voltages of one junction.
   function automatic voltages_type connect_junction(junction_type j);
      voltages_type r;
      logic signed [127:0] num, q, total;
      r = '{default: '0};
      if (j.kind == KIND_BOUND && j.coef != 0) begin
         r.link_a = scale_by_coef(j.vra, j.coef);
         r.stub_a = scale_by_coef(j.vsa, j.coef);
      end else if (j.kind == KIND_COND) begin
         r.link_a = clamp_volt(-128'(j.vra));
         r.stub_a = clamp_volt(-128'(j.vsa));
      end else if (j.kind == KIND_BOUND || j.kind == KIND_PAIR) begin
         r.pvalid = (j.kind == KIND_PAIR);
         if (r.pvalid && j.cond) return r;
         num = 128'(j.vra) * 128'(j.yla) + 128'(j.vsa) * 128'(j.ysa);
         if (r.pvalid) begin
            num += 128'(j.vrb) * 128'(j.ylb) + 128'(j.vsb) * 128'(j.ysb);
            total = 128'(j.yla) + 128'(j.ysa) + 128'(j.ylb) + 128'(j.ysb);
         end else begin
            total = 128'(j.yla) + 128'(j.ysa) + 128'(j.yb);
         end
         if (total == 0) begin
            r.derr = 1'b1;
            return r;
         end
         // SystemVerilog signed division truncates toward zero.
         q = (num + num) / total;
         r.link_a = clamp_volt(q - 128'(j.vra));
         r.stub_a = clamp_volt(q - 128'(j.vsa));
         if (r.pvalid) begin
            r.link_b = clamp_volt(q - 128'(j.vrb));
            r.stub_b = clamp_volt(q - 128'(j.vsb));
         end
      end
      return r;
   endfunction

   function automatic logic signed [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 7)) - 3;
         default: return $signed($urandom());
      endcase
   endfunction

   // Realistic admittance: small non-negative values, sometimes anything.
   function automatic logic signed [AW-1:0] any_admit();
      if ($urandom_range(0, 9) == 0) return any_word();
      return $signed($urandom_range(0, 32'h0400_0000));
   endfunction

   function automatic logic signed [VW-1:0] any_volt();
      if ($urandom_range(0, 4) == 0) return any_word();
      return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
   endfunction

   function automatic junction_type random_junction();
      junction_type j;
      j.kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 19) != 0 && j.kind == 2'd3) j.kind = KIND_PAIR;
      j.vra = any_volt();
      j.vsa = any_volt();
      j.yla = any_admit();
      j.ysa = any_admit();
      j.yb = any_admit();
      case ($urandom_range(0, 4))
         0, 1: j.coef = '0;
         2: j.coef = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         3: j.coef = 16'($urandom());
         default: j.coef = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      endcase
      j.vrb = any_volt();
      j.vsb = any_volt();
      j.ylb = any_admit();
      j.ysb = any_admit();
      j.cond = ($urandom_range(0, 7) == 0);
      // Force a zero admittance total now and then.
      if ($urandom_range(0, 24) == 0) begin
         if (j.kind == KIND_PAIR) j.ysb = -(j.yla + j.ysa + j.ylb);
         else j.yb = -(j.yla + j.ysa);
      end
      return j;
   endfunction

   // Present one beat and hold it until accepted.
   task automatic send_junction(junction_type j);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= j.kind;
      req_reflected_link_a <= j.vra;
      req_stub_volt_a <= j.vsa;
      req_link_admit_a <= j.yla;
      req_stub_admit_a <= j.ysa;
      req_bound_admit <= j.yb;
      req_refl_coef <= j.coef;
      req_reflected_link_b <= j.vrb;
      req_stub_volt_b <= j.vsb;
      req_link_admit_b <= j.ylb;
      req_stub_admit_b <= j.ysb;
      req_conductor_face <= j.cond;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Prediction at acceptance, checking of results.
   always @(posedge clock) begin
      junction_type j;
      voltages_type e;
      if (!reset && req_valid && req_ready) begin
         j = '{req_kind, req_reflected_link_a, req_stub_volt_a, req_link_admit_a,
               req_stub_admit_a, req_bound_admit, req_refl_coef, req_reflected_link_b,
               req_stub_volt_b, req_link_admit_b, req_stub_admit_b, req_conductor_face};
         expected_q = {expected_q, connect_junction(j)};
      end
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (expected_q.size() == 0) begin
            $error("result beat with no expectation waiting");
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_incident_link_a !== e.link_a) begin
               $error("incident_link_a exp %0d got %0d", e.link_a, rsp_incident_link_a);
               errors++;
            end
            if (rsp_new_stub_a !== e.stub_a) begin
               $error("new_stub_a exp %0d got %0d", e.stub_a, rsp_new_stub_a);
               errors++;
            end
            if (rsp_incident_link_b !== e.link_b) begin
               $error("incident_link_b exp %0d got %0d", e.link_b, rsp_incident_link_b);
               errors++;
            end
            if (rsp_new_stub_b !== e.stub_b) begin
               $error("new_stub_b exp %0d got %0d", e.stub_b, rsp_new_stub_b);
               errors++;
            end
            if (rsp_partner_valid !== e.pvalid) begin
               $error("partner_valid exp %0b got %0b", e.pvalid, rsp_partner_valid);
               errors++;
            end
            if (rsp_divide_error !== e.derr) begin
               $error("divide_error exp %0b got %0b", e.derr, rsp_divide_error);
               errors++;
            end
            if (e.pvalid) pair_count++;
            if (e.derr) derr_count++;
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!done_sending || expected_q.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Result-side stalls in bursts.
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         if (quiet_tail) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            n = $urandom_range(1, 17);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (n) @(negedge clock);
         end
      end
   end

   initial begin
      stim_row_type rows[DIRECTED_COUNT];
      junction_type z;
      voltages_type vz;
      voltages_type got;
      int drain;
      z = '{KIND_BOUND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0};
      vz = '{default: '0};

      // Directed table; typed results only where they are obvious.
      foreach (rows[i]) rows[i] = '{z, 1'b0, vz};
      // All-zero matched boundary: zero total admittance.
      rows[0].typed = 1; rows[0].v.derr = 1;
      // Conductor boundary negates; the minimum saturates to the maximum.
      rows[1].j.kind = KIND_COND; rows[1].j.vra = VMIN; rows[1].j.vsa = VMAX;
      rows[1].typed = 1; rows[1].v.link_a = VMAX; rows[1].v.stub_a = -VMAX;
      // Pair with a conductor face is zeroed.
      rows[2].j = '{KIND_PAIR, VMAX, VMIN, AMAX, AMIN, 5, 7, VMIN, VMAX, AMAX, AMIN, 1'b1};
      rows[2].typed = 1; rows[2].v.pvalid = 1;
      // Undefined kind returns all zero.
      rows[3].j = '{2'd3, VMAX, VMIN, AMAX, AMIN, AMAX, 16'sd100, VMAX, VMIN, 1, 1, 1'b0};
      rows[3].typed = 1;
      // Pair with zero total admittance.
      rows[4].j = '{KIND_PAIR, VONE, VONE, YONE, -YONE, 0, 0, VONE, VONE, YONE, -YONE, 1'b0};
      rows[4].typed = 1; rows[4].v.pvalid = 1; rows[4].v.derr = 1;
      // Scaled boundary with unit coefficients.
      rows[5].j = '{KIND_BOUND, VMAX, VMIN, 0, 0, 0, 16'sd16384, 0, 0, 0, 0, 1'b0};
      rows[5].typed = 1; rows[5].v.link_a = VMAX; rows[5].v.stub_a = VMIN;
      rows[6].j = '{KIND_BOUND, VMIN, VMAX, 0, 0, 0, -16'sd16384, 0, 0, 0, 0, 1'b0};
      rows[6].typed = 1; rows[6].v.link_a = VMAX; rows[6].v.stub_a = -VMAX;
      // Remaining rows go to the predictor.
      rows[7].j = '{KIND_BOUND, VONE, 2 * VONE, YONE, YONE, YONE, 0, 0, 0, 0, 0, 1'b0};
      rows[8].j = '{KIND_PAIR, VONE, -VONE, YONE, 2 * YONE, 0, 0, 3 * VONE, 0, YONE, YONE,
                    1'b0};
      rows[9].j = '{KIND_BOUND, VMAX, VMAX, AMAX, AMAX, AMIN, 0, 0, 0, 0, 0, 1'b0};
      rows[10].j = '{KIND_BOUND, VMIN, VMIN, AMIN, AMIN, 1, 0, 0, 0, 0, 0, 1'b0};
      rows[11].j = '{KIND_PAIR, VMAX, VMIN, AMAX, AMAX, 0, 0, VMAX, VMIN, AMIN, 1, 1'b0};
      rows[12].j = '{KIND_PAIR, VMIN, VMIN, 1, 0, 0, 0, VMIN, VMIN, 0, 0, 1'b0};
      rows[13].j = '{KIND_BOUND, VONE, VONE, -YONE, 0, 0, 0, 0, 0, 0, 0, 1'b0};
      rows[14].j = '{KIND_BOUND, VMAX, VMIN, 0, 0, 0, 16'sd8192, 0, 0, 0, 0, 1'b0};
      rows[15].j = '{KIND_BOUND, 3, -3, 0, 0, AMAX, -16'sd8192, 0, 0, 0, 0, 1'b0};
      rows[16].j = '{KIND_BOUND, 1, -1, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0, 1'b0};
      rows[17].j = '{KIND_BOUND, VMAX, VMIN, 0, 0, 0, 16'sh8000, 0, 0, 0, 0, 1'b0};
      rows[18].j = '{KIND_COND, 0, -1, 0, 0, 0, 0, VMAX, VMAX, 1, 1, 1'b1};
      rows[19].j = '{KIND_PAIR, -VONE, VONE, -YONE, -YONE, 0, 0, VONE, 5, -YONE, 1, 1'b0};
      rows[20].j = '{KIND_BOUND, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0, 1'b0};
      rows[21].j = '{2'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].typed) begin
            got = connect_junction(rows[i].j);
            if (got !== rows[i].v) begin
               $error("directed row %0d: predictor disagrees with typed result", i);
               errors++;
            end
         end
         send_junction(rows[i].j);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT - 200) quiet_tail = 1;
         send_junction(random_junction());
      end
      req_valid <= 1'b0;
      done_sending = 1;

      while (expected_q.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < 2 * LATENCY) begin
         @(posedge clock);
         drain++;
      end

      $display("Sent %0d junctions (%0d directed); %0d results checked.",
               DIRECTED_COUNT + RANDOM_COUNT, DIRECTED_COUNT, beats_out);
      $display("Inner pairs: %0d, zero-admittance divides: %0d.", pair_count, derr_count);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* tlm_junction_connect.f */
design/tjc_pkg.sv
design/tjc_div_stage.sv
design/tlm_junction_connect.sv
tb/sv/tb_tlm_junction_connect.sv
